>>> hdl/assert_macros.svh
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication check, reset disables
`define CHK_IMPL(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);
// next-cycle implication check, reset disables
`define CHK_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);
`endif

>>> hdl/sha256_pkg.sv
// sha-256 shared types, constants and round functions
// no dependencies
package sha256_pkg;
  localparam int BlockBytesDef = 64;
  localparam int QueueDepth = 2;
  localparam int CountBits = 61;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ROUND, ST_ADD, ST_OUT
  } back_state_t;

  typedef enum logic [1:0] {
    PH_DATA, PH_PAD1, PH_PAD2
  } pad_phase_t;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction
endpackage

>>> hdl/sha256_message_digest_core.sv
// sha-256 core top level: front, item queue, back end
// depends on sha256_pkg, sha256_front, sha256_queue, sha256_back, assert_macros.svh
`include "assert_macros.svh"
// hashes a byte-per-item message; on the end item it pads, compresses one or two final
// blocks and emits eight 32-bit digest words, word 0 first. the front takes an item every
// cycle while the two-entry queue has room; the back takes one item per cycle while idle,
// and each full 64-byte block goes through the single shared round unit (load, 64 rounds,
// add), during which the back takes no items. an end item adds one or two blocks plus the
// eight digest words on the output. no clearing pass after reset.
module sha256_message_digest_core import sha256_pkg::*; #(
  parameter int BLOCK_BYTES = BlockBytesDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  input  logic        in_valid,
  output logic        in_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word,
  output logic        out_valid,
  input  logic        out_stall
);
  // queue handshake between front and back
  logic        push, full, pop, not_empty;
  cmd_t        push_item, pop_item;

  sha256_front u_front (
    .data_byte, .byte_present, .end_of_message,
    .valid(in_valid), .stall(in_stall), .push, .push_item, .full);

  sha256_queue u_queue (
    .clk, .rst, .push, .push_item, .full, .pop, .pop_item, .not_empty);

  sha256_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back (
    .clk, .rst, .cmd(pop_item), .cmd_ready(not_empty), .pop,
    .digest_word, .word_index, .last_word, .valid(out_valid), .stall(out_stall));

  // never pop an empty queue or push a full one
  `CHK_IMPL(a_pop_nonempty, clk, rst, pop, not_empty, "pop from empty queue")
  `CHK_IMPL(a_push_room, clk, rst, push, !full, "push into full queue")
  // the last digest word ends the output burst
  `CHK_NEXT(a_last_ends, clk, rst, out_valid && !out_stall && last_word, !out_valid,
            "output continues after last word")
endmodule

>>> hdl/sha256_queue.sv
// two-entry item queue between front and back
// depends on sha256_pkg
module sha256_queue import sha256_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_item,
  output logic full,
  input  logic pop,
  output cmd_t pop_item,
  output logic not_empty
);
  cmd_t       mem [QueueDepth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'(QueueDepth));
  assign not_empty = (count != 2'd0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

>>> hdl/sha256_front.sv
// input front: takes items, drops empty non-end ones, feeds the queue
// depends on sha256_pkg
module sha256_front import sha256_pkg::*; (
  input  logic [7:0] data_byte,
  input  logic       byte_present,
  input  logic       end_of_message,
  input  logic       valid,
  output logic       stall,
  output logic       push,
  output cmd_t       push_item,
  input  logic       full
);
  logic taken;

  assign stall = full;
  assign taken = valid && !full;
  // items with neither a byte nor an end change nothing
  assign push = taken && (byte_present || end_of_message);
  assign push_item = '{data: data_byte, present: byte_present, last: end_of_message};
endmodule

>>> hdl/sha256_back.sv
// back end: block words, padding, round engine and digest output
// depends on sha256_pkg
module sha256_back import sha256_pkg::*; #(
  parameter int BLOCK_BYTES = BlockBytesDef
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic        cmd_ready,
  output logic        pop,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word,
  output logic        valid,
  input  logic        stall
);
  localparam int FillBits = $clog2(BLOCK_BYTES);
  localparam int WordCnt = BLOCK_BYTES / 4;
  localparam int LenOffset = BLOCK_BYTES - 8;

  back_state_t state, state_next;
  pad_phase_t  phase;
  logic [FillBits-1:0] fill;
  logic [CountBits-1:0] count;
  logic [31:0] h [8];
  logic [31:0] v [8];
  // block words: filled byte by byte, then shifted as the message schedule
  logic [31:0] w [WordCnt];
  logic [31:0] blk_next [WordCnt];
  logic [6:0]  rnd;
  logic [2:0]  oidx;
  logic        second;   // end needs an extra padding block
  logic        full_after;
  logic [FillBits:0] padpos;
  logic [63:0] bits;
  logic [63:0] bits_in;

  assign pop = (state == ST_IDLE) && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  assign full_after = cmd.present && (fill == FillBits'(BLOCK_BYTES - 1));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (pop && (full_after || cmd.last)) state_next = ST_LOAD;
      ST_LOAD: state_next = ST_ROUND;
      ST_ROUND: if (rnd == 7'd63) state_next = ST_ADD;
      ST_ADD: begin
        if (phase == PH_DATA) state_next = ST_IDLE;
        else if (phase == PH_PAD1 && second) state_next = ST_LOAD;
        else state_next = ST_OUT;
      end
      ST_OUT: if (!stall && oidx == 3'd7) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  logic [31:0] wn, t1, t2, e, a;
  assign wn = w[0];
  assign e = v[4];
  assign a = v[0];
  assign t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
              + RoundK[rnd[5:0]] + wn;
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) ^ 32'h0;
  logic [31:0] mj;
  assign mj = (a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]);
  logic [31:0] wnew;
  assign wnew = w[0] + sig0(w[1]) + w[9] + sig1(w[14]);

  // pad byte position and bit length as they stand after this item's byte
  assign padpos = cmd.present ? {1'b0, fill} + 1'b1 : {1'b0, fill};
  assign bits = {count, 3'b000};
  assign bits_in = {count + CountBits'(cmd.present), 3'b000};

  // block words after taking the item at the head of the queue
  always_comb begin
    for (int j = 0; j < WordCnt; j++) blk_next[j] = w[j];
    if (cmd.present) begin
      for (int k = 0; k < 4; k++) begin
        if (fill[1:0] == 2'(k)) blk_next[fill[FillBits-1:2]][8*(3-k) +: 8] = cmd.data;
      end
    end
    if (cmd.last && !full_after) begin
      for (int j = 0; j < WordCnt; j++) begin
        for (int k = 0; k < 4; k++) begin
          if (4*j + k == int'(padpos)) blk_next[j][8*(3-k) +: 8] = PadByte;
          else if (4*j + k > int'(padpos)) blk_next[j][8*(3-k) +: 8] = 8'h00;
        end
      end
      if (int'(padpos) + 1 <= LenOffset) begin
        blk_next[WordCnt-2] = bits_in[63:32];
        blk_next[WordCnt-1] = bits_in[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      count <= '0;
      phase <= PH_DATA;
      second <= 1'b0;
      rnd <= '0;
      oidx <= '0;
      for (int i = 0; i < 8; i++) h[i] <= InitHash[i];
    end else begin
      case (state)
        ST_IDLE: if (pop) begin
          for (int j = 0; j < WordCnt; j++) w[j] <= blk_next[j];
          if (cmd.present) begin
            fill <= fill + 1'b1;
            count <= count + 1'b1;
          end
          // an end whose byte fills the block pads entirely in the next one
          if (cmd.last) begin
            phase <= PH_PAD1;
            second <= full_after || (int'(padpos) + 1 > LenOffset);
          end
        end
        ST_LOAD: begin
          for (int i = 0; i < 8; i++) v[i] <= h[i];
          rnd <= '0;
        end
        ST_ROUND: begin
          for (int i = 0; i < WordCnt - 1; i++) w[i] <= w[i+1];
          w[WordCnt-1] <= wnew;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2 + mj;
          rnd <= rnd + 1'b1;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          if (phase == PH_PAD1 && second) begin
            phase <= PH_PAD2;
            // fill is zero only when the end byte completed the block
            w[0] <= (fill == '0) ? {PadByte, 24'h000000} : 32'h0;
            for (int j = 1; j < WordCnt - 2; j++) w[j] <= 32'h0;
            w[WordCnt-2] <= bits[63:32];
            w[WordCnt-1] <= bits[31:0];
          end
          oidx <= '0;
        end
        ST_OUT: if (!stall) begin
          oidx <= oidx + 1'b1;
          if (oidx == 3'd7) begin
            for (int i = 0; i < 8; i++) h[i] <= InitHash[i];
            fill <= '0;
            count <= '0;
            phase <= PH_DATA;
            second <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign valid = (state == ST_OUT);
  assign digest_word = h[oidx];
  assign word_index = oidx;
  assign last_word = (oidx == 3'd7);
endmodule

>>> tb/tb.sv
// self-checking testbench for sha256_message_digest_core: byte items in, digest words out
// depends on sha256_pkg (round constants, initial hash) and the core rtl
`timescale 1ns / 1ps
module tb;
  import sha256_pkg::*;

  localparam int ClkPeriod = 12;
  localparam int DrainCycles = 400;

  // one row of the directed table; has_known means the digest is typed in
  typedef struct {
    logic [7:0]  data;
    logic        present;
    logic        last;
    logic        has_known;
    logic [31:0] known_w0;
  } stim_row_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic        clk;
  logic        rst;
  logic [7:0]  data_byte;
  logic        byte_present;
  logic        end_of_message;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  logic        out_valid;
  logic        out_stall;

  sha256_message_digest_core u_top (
    .clk(clk), .rst(rst),
    .data_byte(data_byte), .byte_present(byte_present), .end_of_message(end_of_message),
    .in_valid(in_valid), .in_stall(in_stall),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word),
    .out_valid(out_valid), .out_stall(out_stall)
  );

  // predictor state for the message in progress
  logic [31:0] hash_acc [8];
  logic [7:0]  block_bytes [64];
  logic [5:0]  block_fill;
  logic [60:0] msg_len;

  digest_word_t pending_words[$];
  int  errors = 0;
  int  words_checked = 0;
  int  digests_seen = 0;
  int  items_sent = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_recv = 0;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one 64-round compression of block_bytes into hash_acc
  task automatic compress_into_hash();
    logic [31:0] sched [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int t = 0; t < 16; t++)
      sched[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3);
      s1 = ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10);
      sched[t] = sched[t-16] + s0 + sched[t-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hash_acc[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + sched[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_acc[i] += v[i];
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) hash_acc[i] = InitHash[i];
    block_fill = '0;
    msg_len = '0;
  endtask

  // predicts one accepted item; on an end item it queues the eight digest words
  task automatic predict_digest(input logic [7:0] d, input logic p, input logic e);
    int fill;
    logic [63:0] bit_len;
    if (p) begin
      block_bytes[block_fill] = d;
      block_fill = block_fill + 6'd1;
      msg_len = msg_len + 61'd1;
      if (block_fill == 0) compress_into_hash();
    end
    if (e) begin
      fill = block_fill;
      block_bytes[fill] = PadByte;
      fill++;
      for (int i = fill; i < 64; i++) block_bytes[i] = 8'h00;
      if (fill > 56) begin
        compress_into_hash();
        for (int i = 0; i < 56; i++) block_bytes[i] = 8'h00;
      end
      bit_len = {msg_len, 3'b000};
      for (int i = 0; i < 8; i++) block_bytes[56 + i] = bit_len[8*(7-i) +: 8];
      compress_into_hash();
      for (int i = 0; i < 8; i++)
        pending_words.push_back('{hash_acc[i], 3'(i), logic'(i == 7)});
      restart_message();
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // fail-safe end of run
  initial begin
    #(ClkPeriod * 900000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: random stall, plus a long hold-off while hold_recv is set
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // digest word checker
  always @(posedge clk) begin
    digest_word_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("digest word with nothing expected: word=%h index=%0d", digest_word, word_index);
        errors++;
      end else begin
        exp_w = pending_words.pop_front();
        words_checked++;
        if (digest_word !== exp_w.word) begin
          $error("digest_word expected %h actual %h", exp_w.word, digest_word);
          errors++;
        end
        if (word_index !== exp_w.index) begin
          $error("word_index expected %0d actual %0d", exp_w.index, word_index);
          errors++;
        end
        if (last_word !== exp_w.last) begin
          $error("last_word expected %0d actual %0d", exp_w.last, last_word);
          errors++;
        end
        if (exp_w.last) digests_seen++;
      end
    end
  end

  // known word 0 of a digest, checked ahead of the predictor output
  task automatic check_known_w0(input logic [31:0] w0);
    if (pending_words.size() >= 8 && pending_words[pending_words.size() - 8].word !== w0) begin
      $error("digest_word expected %h actual %h",
             w0, pending_words[pending_words.size() - 8].word);
      errors++;
    end
  endtask

  // presents one item, holding it until accepted; gaps before it at random
  task automatic send_item(input logic [7:0] d, input logic p, input logic e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= d;
    byte_present <= p;
    end_of_message <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_digest(d, p, e);
    items_sent++;
  endtask

  // a message of len random bytes; the end rides on the last byte or on an empty item
  task automatic send_message(input int len);
    logic split_end;
    split_end = (len == 0) || $urandom_range(1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (i == len - 1) && !split_end);
    end
    if (split_end) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  stim_row_t directed [$];
  int drain;
  int msg_len_pick;
  int rand_base;

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    byte_present = 1'b0;
    end_of_message = 1'b0;
    restart_message();
    for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty message, "abc", bytes 00/ff, idle item, split end
    directed.push_back('{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442});
    directed.push_back('{8'h61, 1'b1, 1'b0, 1'b0, 32'h0});
    directed.push_back('{8'h62, 1'b1, 1'b0, 1'b0, 32'h0});
    directed.push_back('{8'hff, 1'b0, 1'b0, 1'b0, 32'h0});
    directed.push_back('{8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf});
    directed.push_back('{8'h00, 1'b1, 1'b0, 1'b0, 32'h0});
    directed.push_back('{8'hff, 1'b1, 1'b0, 1'b0, 32'h0});
    directed.push_back('{8'h55, 1'b0, 1'b1, 1'b0, 32'h0});
    directed.push_back('{8'hff, 1'b1, 1'b1, 1'b0, 32'h0});
    directed.push_back('{8'haa, 1'b0, 1'b1, 1'b0, 32'h0});
    foreach (directed[i]) begin
      send_item(directed[i].data, directed[i].present, directed[i].last);
      if (directed[i].has_known) check_known_w0(directed[i].known_w0);
    end

    // padding edges: 55, 56 and 64 bytes straddle the length field and block edge
    send_message(55);
    send_message(56);
    send_message(64);

    // random messages under three idling phases
    rand_base = items_sent;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 64 : 0;
      recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 24 : 0;
      while (items_sent < rand_base + 90 * (phase + 1)) begin
        msg_len_pick = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(12);
        // receiver holds off for a long stretch while a burst of short messages goes in
        if (phase == 2 && !hold_recv && items_sent > rand_base + 200) begin
          fork
            begin
              hold_recv = 1'b1;
              repeat (600) @(posedge clk);
              hold_recv = 1'b0;
            end
          join_none
        end
        send_message(msg_len_pick);
      end
    end
    in_valid <= 1'b0;

    drain = 0;
    while (pending_words.size() != 0 && drain < 200000) begin
      @(posedge clk);
      drain++;
    end
    repeat (DrainCycles) @(posedge clk);
    $display("run covered %0d items, %0d digests, %0d words checked",
             items_sent, digests_seen, words_checked);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
